FILE: src/tmrm_pkg.sv
// Package with shared widths, codes, command and status types and the sine function.
`timescale 1ns / 1ps
package tmrm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARCH_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_OF_VIEW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLUMNS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RETINA_DISTANCE = 3'd5;

    localparam logic REQ_TILE_WRITE = 1'b0;
    localparam logic REQ_CAST       = 1'b1;

    localparam int TILE_W   = 5;
    localparam int POS_IN_W = 21;
    localparam int ANGLE_W  = 16;
    localparam int COLUMN_W = 10;
    localparam int DIST_W   = 21;
    localparam int SHADE_W  = 2;
    localparam int ROW_W    = 8;

    localparam int GRID_COLS = 32;
    localparam int GRID_ROWS = 32;

    localparam int DIV_N = 34;
    localparam int DIV_M = 25;

    localparam logic [1:0] DIV_SEL_ANGLE = 2'd0;
    localparam logic [1:0] DIV_SEL_END   = 2'd1;
    localparam logic [1:0] DIV_SEL_SKY   = 2'd2;

    localparam logic [1:0] SHADE_NEAR = 2'd0;
    localparam logic [1:0] SHADE_MID  = 2'd1;
    localparam logic [1:0] SHADE_FAR  = 2'd2;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef struct packed {
        logic       clear;
        logic       tile_wr;
        logic       load;
        logic       div_start;
        logic       div_take;
        logic [1:0] div_sel;
        logic       rom_rd;
        logic       trig;
        logic       step;
        logic       set_hit;
        logic       finish;
        logic       out_load;
    } tmrm_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic step_ok;
        logic tile_solid;
        logic hit;
        logic sky_neg;
        logic out_free;
    } tmrm_stat_t;

    // Sine of a quarter-wave phase in Q16, from a Taylor series in Q30.
    function automatic logic [16:0] quarter_sine(input logic [14:0] u);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (64'(u) * TWO_PI_Q30) >> 16;
        x2   = (x * x) >> 30;
        term = ((x * x2) >> 30) / 64'd6;
        sum  = $signed(x) - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0)
            sum = 64'sd0;
        sum = (sum + 64'sd8192) >>> 14;
        if (sum > 64'sd65536)
            sum = 64'sd65536;
        return sum[16:0];
    endfunction

    function automatic logic signed [17:0] phase_sine(input logic [15:0] p);
        logic [16:0] v;
        v = p[14] ? quarter_sine(15'(15'd16384 - {1'b0, p[13:0]}))
                  : quarter_sine({1'b0, p[13:0]});
        return p[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

FILE: src/tmrm_if.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface tmrm_req_if;
    import tmrm_pkg::*;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [TILE_W-1:0]   tile_x;
    logic [TILE_W-1:0]   tile_y;
    logic                tile_solid;
    logic [POS_IN_W-1:0] eye_x;
    logic [POS_IN_W-1:0] eye_y;
    logic [ANGLE_W-1:0]  view_angle;
    logic [COLUMN_W-1:0] column;
    modport source (output valid, req_type, tile_x, tile_y, tile_solid, eye_x, eye_y,
                    view_angle, column, input ready);
    modport sink (input valid, req_type, tile_x, tile_y, tile_solid, eye_x, eye_y,
                  view_angle, column, output ready);
endinterface

interface tmrm_res_if;
    import tmrm_pkg::*;
    logic               valid;
    logic               ready;
    logic [DIST_W-1:0]  distance;
    logic               hit;
    logic [SHADE_W-1:0] shade;
    logic [ROW_W-1:0]   first_wall_row;
    logic [ROW_W-1:0]   first_floor_row;
    modport source (output valid, distance, hit, shade, first_wall_row, first_floor_row,
                    input ready);
    modport sink (input valid, distance, hit, shade, first_wall_row, first_floor_row,
                  output ready);
endinterface

FILE: src/tmrm_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module tmrm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tmrm_pkg::DIV_N-1:0] dividend,
    input  logic [tmrm_pkg::DIV_M-1:0] divisor,
    output logic [tmrm_pkg::DIV_N-1:0] quotient,
    output logic                       done
);
    import tmrm_pkg::*;

    localparam int CNT_W = $clog2(DIV_N + 1);

    logic [DIV_M-1:0] rem_reg;
    logic [DIV_N-1:0] quo_reg;
    logic [DIV_M-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_M:0]   trial;
    logic             ge;
    logic [DIV_M:0]   rem_next;

    assign trial    = {rem_reg, quo_reg[DIV_N-1]};
    assign ge       = trial >= {1'b0, dsr_reg};
    assign rem_next = ge ? trial - {1'b0, dsr_reg} : trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_N);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next[DIV_M-1:0];
            quo_reg <= {quo_reg[DIV_N-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

FILE: src/tmrm_datapath.sv
// Datapath: registers, tile memory, sine table, march position and row projection.
`timescale 1ns / 1ps
module tmrm_datapath #(
    parameter int MAX_MARCH_STEPS  = 4096,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tmrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmrm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  tmrm_pkg::tmrm_cmd_t             cmd,
    output tmrm_pkg::tmrm_stat_t            stat,
    input  logic [tmrm_pkg::TILE_W-1:0]     tile_x,
    input  logic [tmrm_pkg::TILE_W-1:0]     tile_y,
    input  logic                            tile_solid,
    input  logic [tmrm_pkg::POS_IN_W-1:0]   eye_x,
    input  logic [tmrm_pkg::POS_IN_W-1:0]   eye_y,
    input  logic [tmrm_pkg::ANGLE_W-1:0]    view_angle,
    input  logic [tmrm_pkg::COLUMN_W-1:0]   column,
    input  logic                            res_ready,
    output logic                            res_valid,
    output logic [tmrm_pkg::DIST_W-1:0]     distance,
    output logic                            hit,
    output logic [tmrm_pkg::SHADE_W-1:0]    shade,
    output logic [tmrm_pkg::ROW_W-1:0]      first_wall_row,
    output logic [tmrm_pkg::ROW_W-1:0]      first_floor_row
);
    import tmrm_pkg::*;

    localparam int MAP_DEPTH = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int X_W       = $clog2(GRID_COLS);
    localparam int Y_W       = $clog2(GRID_ROWS);
    localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH);
    localparam int STEP_W    = $clog2(MAX_MARCH_STEPS + 1);
    localparam int D_W       = 16 + STEP_W;
    localparam int POS_W     = 36 + STEP_W;
    localparam int HI_W      = POS_W - 32;

    logic [20:0] view_limit_reg;
    logic [15:0] march_step_reg;
    logic [15:0] fov_reg;
    logic [10:0] cols_reg;
    logic [7:0]  rows_reg;
    logic [15:0] retina_reg;
    logic [15:0] stp;
    logic [10:0] cols;

    logic       tile_mem [MAP_DEPTH];
    logic [ADDR_W:0] clr_cnt_reg;
    logic            mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic            mem_wdata;
    logic            wr_in_range;
    logic            rd_reg;
    logic            offmap_reg;

    logic signed [17:0] sin_rom [SINE_TABLE_DEPTH];
    logic signed [17:0] cos_rom [SINE_TABLE_DEPTH];
    logic signed [17:0] sin_reg;
    logic signed [17:0] cos_reg;

    logic [POS_IN_W-1:0] eye_x_reg;
    logic [POS_IN_W-1:0] eye_y_reg;
    logic [15:0]         view_reg;
    logic [9:0]          column_reg;
    logic [15:0]         ang_q_reg;
    logic [15:0]         angle;
    logic [31:0]         idx_prod;
    logic [IDX_W-1:0]    idx;

    logic signed [34:0]      sx_reg;
    logic signed [34:0]      sy_reg;
    logic signed [POS_W-1:0] px_reg;
    logic signed [POS_W-1:0] py_reg;
    logic signed [POS_W-1:0] px_next;
    logic signed [POS_W-1:0] py_next;
    logic [STEP_W-1:0]       k_reg;
    logic [D_W-1:0]          d_reg;
    logic                    hit_reg;
    logic                    offmap;
    logic [X_W-1:0]          tx;
    logic [Y_W-1:0]          ty;
    logic [ADDR_W-1:0]       raddr;

    logic [22:0]       bd;
    logic [20:0]       dist_reg;
    logic [1:0]        shade_reg;
    logic [DIV_M-1:0]  den_reg;
    logic [DIV_N-1:0]  end_reg;
    logic [DIV_N-1:0]  sky_reg;
    logic              sky_neg_reg;
    logic [7:0]        ffr_reg;
    logic [7:0]        fwr_reg;

    logic [DIV_N-1:0] div_dividend;
    logic [DIV_M-1:0] div_divisor;
    logic [DIV_N-1:0] div_quot;
    logic             div_done;
    logic [7:0]       row_clamped;

    logic             out_valid_reg;
    logic [20:0]      out_dist_reg;
    logic             out_hit_reg;
    logic [1:0]       out_shade_reg;
    logic [7:0]       out_fwr_reg;
    logic [7:0]       out_ffr_reg;

    assign stp  = (march_step_reg == 16'd0) ? 16'd1 : march_step_reg;
    assign cols = (cols_reg == 11'd0) ? 11'd1 : cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_limit_reg <= 21'd229376;
            march_step_reg <= 16'd66;
            fov_reg        <= 16'd16384;
            cols_reg       <= 11'd120;
            rows_reg       <= 8'd55;
            retina_reg     <= 16'd32768;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VIEW_LIMIT:      view_limit_reg <= cfg_data;
                CFG_MARCH_STEP:      march_step_reg <= cfg_data[15:0];
                CFG_FIELD_OF_VIEW:   fov_reg        <= cfg_data[15:0];
                CFG_SCREEN_COLUMNS:  cols_reg       <= cfg_data[10:0];
                CFG_SCREEN_ROWS:     rows_reg       <= cfg_data[7:0];
                CFG_RETINA_DISTANCE: retina_reg     <= cfg_data[15:0];
                default:             ;
            endcase
        end
    end

    // Tile memory with its clearing sweep after reset.
    assign wr_in_range = (32'(tile_x) < GRID_COLS) && (32'(tile_y) < GRID_ROWS);
    assign mem_we      = cmd.clear || (cmd.tile_wr && wr_in_range);
    assign mem_waddr   = cmd.clear ? clr_cnt_reg[ADDR_W-1:0]
                                   : ADDR_W'(32'(tile_y) * GRID_COLS + 32'(tile_x));
    assign mem_wdata   = cmd.clear ? 1'b0 : tile_solid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clear)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            tile_mem[mem_waddr] <= mem_wdata;
        if (cmd.step)
            rd_reg <= tile_mem[raddr];
    end

    // Sine and cosine table, one entry per table phase.
    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++)
    begin : g_rom
        localparam logic [15:0] PH = 16'((longint'(g) * 65536) / SINE_TABLE_DEPTH);
        assign sin_rom[g] = phase_sine(PH);
        assign cos_rom[g] = phase_sine(PH + 16'd16384);
    end

    assign angle    = view_reg - {1'b0, fov_reg[15:1]} + ang_q_reg;
    assign idx_prod = 32'(angle) * 32'(SINE_TABLE_DEPTH);
    assign idx      = idx_prod[16 +: IDX_W];

    // March position and tile lookup for the next step.
    assign px_next = px_reg + POS_W'(sx_reg);
    assign py_next = py_reg + POS_W'(sy_reg);
    assign offmap  = px_next[POS_W-1] || py_next[POS_W-1]
                  || (32'(px_next[POS_W-1:32]) >= GRID_COLS)
                  || (32'(py_next[POS_W-1:32]) >= GRID_ROWS);
    assign tx      = px_next[32 +: X_W];
    assign ty      = py_next[32 +: Y_W];
    assign raddr   = ADDR_W'(32'(ty) * GRID_COLS + 32'(tx));

    assign bd = hit_reg ? 23'(d_reg) : 23'(view_limit_reg) + 23'd65536;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (cmd.trig)
            hit_reg <= 1'b0;
        else if (cmd.set_hit)
            hit_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            eye_x_reg  <= eye_x;
            eye_y_reg  <= eye_y;
            view_reg   <= view_angle;
            column_reg <= column;
        end
        if (cmd.rom_rd)
        begin
            sin_reg <= sin_rom[idx];
            cos_reg <= cos_rom[idx];
        end
        if (cmd.trig)
        begin
            sx_reg <= 35'(sin_reg * $signed({1'b0, stp}));
            sy_reg <= 35'(-(cos_reg * $signed({1'b0, stp})));
            px_reg <= $signed(POS_W'({eye_x_reg, 32'd0} >> 16));
            py_reg <= $signed(POS_W'({eye_y_reg, 32'd0} >> 16));
            k_reg  <= '0;
            d_reg  <= '0;
        end
        if (cmd.step)
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            k_reg      <= k_reg + 1'b1;
            d_reg      <= d_reg + D_W'(stp);
            offmap_reg <= offmap;
        end
        if (cmd.finish)
        begin
            dist_reg <= hit_reg ? 21'(d_reg) : view_limit_reg;
            if ((24'(bd) << 1) <= 24'(view_limit_reg))
                shade_reg <= SHADE_NEAR;
            else if ((25'(bd) << 2) <= 25'(view_limit_reg) * 25'd3)
                shade_reg <= SHADE_MID;
            else
                shade_reg <= SHADE_FAR;
            den_reg     <= DIV_M'(bd) * DIV_M'(3);
            end_reg     <= DIV_N'(rows_reg) * DIV_N'({bd, 1'b0} + 24'(retina_reg));
            sky_neg_reg <= bd < 23'(retina_reg);
            sky_reg     <= (bd < 23'(retina_reg)) ? '0
                           : DIV_N'({rows_reg, 1'b0}) * DIV_N'(bd - 23'(retina_reg));
        end
        if (cmd.div_take)
        begin
            case (cmd.div_sel)
                DIV_SEL_ANGLE: ang_q_reg <= div_quot[15:0];
                DIV_SEL_END:
                begin
                    ffr_reg <= row_clamped;
                    fwr_reg <= hit_reg ? 8'd0 : row_clamped;
                end
                DIV_SEL_SKY:   fwr_reg <= row_clamped;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.div_sel)
            DIV_SEL_ANGLE:
            begin
                div_dividend = DIV_N'(26'(column_reg) * 26'(fov_reg));
                div_divisor  = DIV_M'(cols);
            end
            DIV_SEL_SKY:
            begin
                div_dividend = sky_reg;
                div_divisor  = den_reg;
            end
            default:
            begin
                div_dividend = end_reg;
                div_divisor  = den_reg;
            end
        endcase
    end

    assign row_clamped = (div_quot >= DIV_N'(rows_reg)) ? rows_reg : div_quot[7:0] + 8'd1;

    tmrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    // Output register; a new result loads only when the previous one is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (res_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_dist_reg  <= dist_reg;
            out_hit_reg   <= hit_reg;
            out_shade_reg <= hit_reg ? shade_reg : SHADE_FAR;
            out_fwr_reg   <= fwr_reg;
            out_ffr_reg   <= ffr_reg;
        end
    end

    assign stat.clear_done = clr_cnt_reg == (ADDR_W + 1)'(MAP_DEPTH);
    assign stat.div_done   = div_done;
    assign stat.step_ok    = (32'(k_reg) < MAX_MARCH_STEPS)
                          && ((D_W + 1)'(d_reg) + (D_W + 1)'(stp) < (D_W + 1)'(view_limit_reg));
    assign stat.tile_solid = offmap_reg | rd_reg;
    assign stat.hit        = hit_reg;
    assign stat.sky_neg    = sky_neg_reg;
    assign stat.out_free   = !out_valid_reg || res_ready;

    assign res_valid       = out_valid_reg;
    assign distance        = out_dist_reg;
    assign hit             = out_hit_reg;
    assign shade           = out_shade_reg;
    assign first_wall_row  = out_fwr_reg;
    assign first_floor_row = out_ffr_reg;
endmodule

FILE: src/tmrm_ctrl.sv
// Controller state machine that sequences clearing, tile writes and ray casts.
`timescale 1ns / 1ps
module tmrm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_type,
    output logic                 req_ready,
    input  tmrm_pkg::tmrm_stat_t stat,
    output tmrm_pkg::tmrm_cmd_t  cmd
);
    import tmrm_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_ADIV  = 4'd2;
    localparam logic [3:0] ST_AWAIT = 4'd3;
    localparam logic [3:0] ST_ROM   = 4'd4;
    localparam logic [3:0] ST_TRIG  = 4'd5;
    localparam logic [3:0] ST_STEP  = 4'd6;
    localparam logic [3:0] ST_CHECK = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;
    localparam logic [3:0] ST_EDIV  = 4'd9;
    localparam logic [3:0] ST_EWAIT = 4'd10;
    localparam logic [3:0] ST_SDIV  = 4'd11;
    localparam logic [3:0] ST_SWAIT = 4'd12;
    localparam logic [3:0] ST_DONE  = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        req_ready  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = !stat.clear_done;
                if (stat.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_type == REQ_CAST)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_ADIV;
                    end
                    else
                        cmd.tile_wr = 1'b1;
                end
            end
            ST_ADIV:
            begin
                cmd.div_sel   = DIV_SEL_ANGLE;
                cmd.div_start = 1'b1;
                state_next    = ST_AWAIT;
            end
            ST_AWAIT:
            begin
                cmd.div_sel = DIV_SEL_ANGLE;
                if (stat.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = ST_ROM;
                end
            end
            ST_ROM:
            begin
                cmd.rom_rd = 1'b1;
                state_next = ST_TRIG;
            end
            ST_TRIG:
            begin
                cmd.trig   = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (stat.step_ok)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_CHECK;
                end
                else
                    state_next = ST_FIN;
            end
            ST_CHECK:
            begin
                if (stat.tile_solid)
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = ST_FIN;
                end
                else
                    state_next = ST_STEP;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_EDIV;
            end
            ST_EDIV:
            begin
                cmd.div_sel   = DIV_SEL_END;
                cmd.div_start = 1'b1;
                state_next    = ST_EWAIT;
            end
            ST_EWAIT:
            begin
                cmd.div_sel = DIV_SEL_END;
                if (stat.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = (stat.hit && !stat.sky_neg) ? ST_SDIV : ST_DONE;
                end
            end
            ST_SDIV:
            begin
                cmd.div_sel   = DIV_SEL_SKY;
                cmd.div_start = 1'b1;
                state_next    = ST_SWAIT;
            end
            ST_SWAIT:
            begin
                cmd.div_sel = DIV_SEL_SKY;
                if (stat.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: src/tile_map_ray_marcher_core.sv
// Top level of the tile map ray marcher: controller, datapath and checks.
// Each accepted cast runs an angle division, n march steps (one tile read each) and an
// end-row division, then a sky-row division unless there is no hit or the sky row is
// negative; the divisions share one divider. A tile write is done in the idle state.
// One request at a time; a finished result waits in an output register until it is taken.
// Reset is asynchronous; a clearing pass empties the map before the first request.
`timescale 1ns / 1ps
module tile_map_ray_marcher_core #(
    parameter int MAX_MARCH_STEPS  = 4096,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tmrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmrm_pkg::CFG_DATA_W-1:0] cfg_data,
    tmrm_req_if.sink                        req,
    tmrm_res_if.source                      res
);
    import tmrm_pkg::*;

    tmrm_cmd_t  cmd;
    tmrm_stat_t stat;

    tmrm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tmrm_datapath #(
        .MAX_MARCH_STEPS  (MAX_MARCH_STEPS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .stat            (stat),
        .tile_x          (req.tile_x),
        .tile_y          (req.tile_y),
        .tile_solid      (req.tile_solid),
        .eye_x           (req.eye_x),
        .eye_y           (req.eye_y),
        .view_angle      (req.view_angle),
        .column          (req.column),
        .res_ready       (res.ready),
        .res_valid       (res.valid),
        .distance        (res.distance),
        .hit             (res.hit),
        .shade           (res.shade),
        .first_wall_row  (res.first_wall_row),
        .first_floor_row (res.first_floor_row)
    );

    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.req_type == REQ_CAST) |=> !req.ready)
        else $error("ready stayed high after a cast request was accepted");

    a_no_hit_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.hit) |-> (res.first_wall_row == res.first_floor_row))
        else $error("no-hit result has a wall span");

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.first_wall_row <= res.first_floor_row))
        else $error("wall row lies below floor row");
endmodule
